// ===== hdl/wps_pkg.sv =====
// shared types, constants and the cordic angle table for the waypoint approach sequencer
// no dependencies; imported by the sequencer and its port checker
`timescale 1ns / 1ps
`default_nettype none

package wps_pkg;

    localparam int POS_W      = 16;              // position and register coordinate width
    localparam int DIFF_W     = POS_W + 2;       // goal minus offset position
    localparam int CORDIC_W   = DIFF_W + 3;      // vectoring x/y with gain headroom
    localparam int ANG_W      = 18;              // angle accumulator before saturation
    localparam int ATAN_W     = 14;              // widest table entry is 8192
    localparam int SPEED_W    = 12;
    localparam int RANGE_W    = 16;
    localparam int TICK_W     = 32;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;
    localparam int IN_DATA_W  = 56;
    localparam int OUT_DATA_W = 32;

    localparam int CORDIC_STEPS = 15;
    localparam int STEP_W       = 4;
    localparam int ARRIVE_TOL   = 5;

    localparam logic signed [ANG_W-1:0] QUARTER_TURN = ANG_W'(16384);
    localparam logic signed [ANG_W-1:0] HEAD_MAX     = ANG_W'(32767);
    localparam logic signed [ANG_W-1:0] HEAD_MIN     = -ANG_W'(32768);

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_START_X    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_START_Y    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_GOAL_X     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_GOAL_Y     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_OBST_LIMIT = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_CRUISE     = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_MATCH      = 3'd6;

    typedef enum logic [1:0] {
        MODE_WAIT = 2'd0,
        MODE_MOVE = 2'd1,
        MODE_OBST = 2'd2,
        MODE_DONE = 2'd3
    } mode_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ITER,
        ST_OUT
    } seq_state_t;

    // atan(2^-i) in units of pi/32768
    function automatic logic [ATAN_W-1:0] atan_entry(input logic [STEP_W-1:0] i);
        logic [ATAN_W-1:0] a;
        unique case (i)
            4'd0:    a = 14'd8192;
            4'd1:    a = 14'd4836;
            4'd2:    a = 14'd2555;
            4'd3:    a = 14'd1297;
            4'd4:    a = 14'd651;
            4'd5:    a = 14'd326;
            4'd6:    a = 14'd163;
            4'd7:    a = 14'd81;
            4'd8:    a = 14'd41;
            4'd9:    a = 14'd20;
            4'd10:   a = 14'd10;
            4'd11:   a = 14'd5;
            4'd12:   a = 14'd3;
            4'd13:   a = 14'd1;
            4'd14:   a = 14'd1;
            default: a = 14'd0;
        endcase
        return a;
    endfunction

endpackage

`default_nettype wire

// ===== hdl/waypoint_approach_sequencer.sv =====
// waypoint approach sequencer: mode control, match timer and iterative cordic heading
// depends on wps_pkg
`timescale 1ns / 1ps
`default_nettype none

// One request on s_ is one control tick; it yields exactly one result on m_. A tick in
// moving mode runs the heading through a single shared CORDIC stage, one vectoring step
// per cycle for 15 steps, before its result is loaded; ticks in the other modes go straight
// to the output state. The block takes one tick at a time: s_tready is high only while no
// tick is in work, and a result held in the output register stalls the next tick only
// until it is taken. Configuration writes are always ready and take effect at once.
module waypoint_approach_sequencer (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    // configuration
    input  wire logic                              cfg_valid,
    output logic                                   cfg_ready,
    input  wire logic [wps_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [wps_pkg::CFG_DATA_W-1:0]    cfg_data,
    // tick input
    input  wire logic                              s_tvalid,
    output logic                                   s_tready,
    // start_cord[0], meas_x[16:1], meas_y[32:17], obstacle_range[48:33], zero fill
    input  wire logic [wps_pkg::IN_DATA_W-1:0]     s_tdata,
    // result output
    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    // drive_issued[0], drive_speed[12:1], heading[28:13], mode_now[30:29], zero fill
    output logic [wps_pkg::OUT_DATA_W-1:0]         m_tdata
);
    import wps_pkg::*;

    // configuration registers
    logic signed [POS_W-1:0]   start_x_reg, start_y_reg, goal_x_reg, goal_y_reg;
    logic [RANGE_W-1:0]        obst_limit_reg;
    logic [SPEED_W-1:0]        cruise_reg;
    logic [TICK_W-1:0]         match_ticks_reg;

    // control state
    seq_state_t                state_reg, state_next;
    mode_t                     mode_reg, mode_next;
    logic [TICK_W-1:0]         match_count_reg, match_count_next;
    logic signed [POS_W-1:0]   last_heading_reg;
    logic [STEP_W-1:0]         step_reg;
    logic                      m_valid_reg;

    // pending result and cordic datapath
    logic                      issued_reg, cordic_reg, zero_reg;
    logic [SPEED_W-1:0]        speed_reg;
    logic signed [CORDIC_W-1:0] x_reg, y_reg;
    logic signed [ANG_W-1:0]   z_reg;
    logic [OUT_DATA_W-1:0]     out_data_reg;

    // input fields
    logic                      in_cord;
    logic signed [POS_W-1:0]   in_meas_x, in_meas_y;
    logic [RANGE_W-1:0]        in_range;

    assign in_cord   = s_tdata[0];
    assign in_meas_x = s_tdata[16:1];
    assign in_meas_y = s_tdata[32:17];
    assign in_range  = s_tdata[48:33];

    logic accept, load_out, out_free, last_step;

    assign cfg_ready = 1'b1;
    assign out_free  = !m_valid_reg || m_tready;
    assign last_step = (step_reg == STEP_W'(CORDIC_STEPS - 1));

    // ---------------- tick decode ----------------
    logic [TICK_W-1:0]          count_inc;
    logic                       timeout, obstacle, arrive;
    mode_t                      mode_eff;
    logic signed [POS_W:0]      pos_x, pos_y;
    logic signed [DIFF_W-1:0]   dx, dy;
    logic signed [CORDIC_W-1:0] dx_w, dy_w, x_init, y_init;
    logic signed [ANG_W-1:0]    z_init;
    logic                       tick_issued, tick_cordic;
    logic [SPEED_W-1:0]         tick_speed;

    always_comb begin
        count_inc = (match_count_reg == '1) ? match_count_reg : match_count_reg + TICK_W'(1);
        timeout   = (count_inc >= match_ticks_reg);
        mode_eff  = timeout ? MODE_DONE : mode_reg;
        obstacle  = (in_range <= obst_limit_reg);

        pos_x = (POS_W+1)'(in_meas_x) + (POS_W+1)'(start_x_reg);
        pos_y = (POS_W+1)'(in_meas_y) + (POS_W+1)'(start_y_reg);
        dx    = DIFF_W'(goal_x_reg) - DIFF_W'(pos_x);
        dy    = DIFF_W'(pos_y) - DIFF_W'(goal_y_reg);
        arrive = (dx > -DIFF_W'(ARRIVE_TOL)) && (dx < DIFF_W'(ARRIVE_TOL)) &&
                 (dy > -DIFF_W'(ARRIVE_TOL)) && (dy < DIFF_W'(ARRIVE_TOL));

        // pre-rotate into the right half plane
        dx_w = CORDIC_W'(dx);
        dy_w = CORDIC_W'(dy);
        if (dx_w < 0) begin
            if (dy_w >= 0) begin
                x_init = dy_w;
                y_init = -dx_w;
                z_init = QUARTER_TURN;
            end else begin
                x_init = -dy_w;
                y_init = dx_w;
                z_init = -QUARTER_TURN;
            end
        end else begin
            x_init = dx_w;
            y_init = dy_w;
            z_init = '0;
        end

        match_count_next = count_inc;
        mode_next        = mode_eff;
        tick_issued      = 1'b1;
        tick_speed       = '0;
        tick_cordic      = 1'b0;
        unique case (mode_eff)
            MODE_WAIT: begin
                tick_issued = 1'b0;
                if (!in_cord) begin
                    match_count_next = '0;
                    mode_next        = MODE_MOVE;
                end
            end
            MODE_MOVE: begin
                tick_speed  = cruise_reg;
                tick_cordic = 1'b1;
                // obstacle wins over arrival
                if (obstacle) begin
                    mode_next = MODE_OBST;
                end else if (arrive) begin
                    mode_next = MODE_DONE;
                end
            end
            MODE_OBST: begin
                if (!obstacle) begin
                    mode_next = MODE_MOVE;
                end
            end
            MODE_DONE: begin
                mode_next = MODE_DONE;
            end
            default: begin
                mode_next = MODE_DONE;
            end
        endcase
    end

    // ---------------- shared cordic stage ----------------
    logic signed [CORDIC_W-1:0] x_sh, y_sh;
    logic signed [ANG_W-1:0]    atan_val, z_sat;

    always_comb begin
        x_sh     = x_reg >>> step_reg;
        y_sh     = y_reg >>> step_reg;
        atan_val = ANG_W'(atan_entry(step_reg));
        if (z_reg > HEAD_MAX) begin
            z_sat = HEAD_MAX;
        end else if (z_reg < HEAD_MIN) begin
            z_sat = HEAD_MIN;
        end else begin
            z_sat = z_reg;
        end
    end

    logic signed [POS_W-1:0] heading_val, new_heading;

    always_comb begin
        new_heading = zero_reg ? '0 : z_sat[POS_W-1:0];
        if (!issued_reg) begin
            heading_val = '0;
        end else if (cordic_reg) begin
            heading_val = new_heading;
        end else begin
            heading_val = last_heading_reg;
        end
    end

    // ---------------- sequencer ----------------
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    state_next = tick_cordic ? ST_ITER : ST_OUT;
                end
            end
            ST_ITER: begin
                if (last_step) begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        s_tready = (state_reg == ST_IDLE);
        accept   = s_tvalid && (state_reg == ST_IDLE);
        load_out = (state_reg == ST_OUT) && out_free;
    end

    // ---------------- control registers ----------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg        <= ST_IDLE;
            mode_reg         <= MODE_WAIT;
            match_count_reg  <= '0;
            last_heading_reg <= '0;
            step_reg         <= '0;
            m_valid_reg      <= 1'b0;
            start_x_reg      <= '0;
            start_y_reg      <= '0;
            goal_x_reg       <= '0;
            goal_y_reg       <= '0;
            obst_limit_reg   <= '0;
            cruise_reg       <= '0;
            match_ticks_reg  <= '1;
        end else begin
            state_reg <= state_next;

            if (cfg_valid) begin
                unique case (cfg_index)
                    CFG_START_X:    start_x_reg     <= cfg_data[POS_W-1:0];
                    CFG_START_Y:    start_y_reg     <= cfg_data[POS_W-1:0];
                    CFG_GOAL_X:     goal_x_reg      <= cfg_data[POS_W-1:0];
                    CFG_GOAL_Y:     goal_y_reg      <= cfg_data[POS_W-1:0];
                    CFG_OBST_LIMIT: obst_limit_reg  <= cfg_data[RANGE_W-1:0];
                    CFG_CRUISE:     cruise_reg      <= cfg_data[SPEED_W-1:0];
                    CFG_MATCH:      match_ticks_reg <= cfg_data[TICK_W-1:0];
                    default: ;
                endcase
            end

            if (accept) begin
                mode_reg        <= mode_next;
                match_count_reg <= match_count_next;
                step_reg        <= '0;
            end else if (state_reg == ST_ITER) begin
                step_reg <= step_reg + STEP_W'(1);
            end

            if (load_out && cordic_reg) begin
                last_heading_reg <= new_heading;
            end

            if (load_out) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // ---------------- datapath registers ----------------
    always_ff @(posedge aclk) begin
        if (accept) begin
            issued_reg <= tick_issued;
            speed_reg  <= tick_speed;
            cordic_reg <= tick_cordic;
            zero_reg   <= (dx == '0) && (dy == '0);
            x_reg      <= x_init;
            y_reg      <= y_init;
            z_reg      <= z_init;
        end else if (state_reg == ST_ITER) begin
            if (y_reg >= 0) begin
                x_reg <= x_reg + y_sh;
                y_reg <= y_reg - x_sh;
                z_reg <= z_reg + atan_val;
            end else begin
                x_reg <= x_reg - y_sh;
                y_reg <= y_reg + x_sh;
                z_reg <= z_reg - atan_val;
            end
        end

        if (load_out) begin
            out_data_reg <= {1'b0, mode_reg, heading_val, speed_reg, issued_reg};
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = out_data_reg;

endmodule

`default_nettype wire

// ===== hdl/wps_checker.sv =====
// port-level checker for the waypoint approach sequencer, bound to the top level
// depends on wps_pkg and waypoint_approach_sequencer
`timescale 1ns / 1ps
`default_nettype none

module wps_checker (
    input wire logic                              aclk,
    input wire logic                              aresetn,
    input wire logic                              s_tvalid,
    input wire logic                              s_tready,
    input wire logic                              m_tvalid,
    input wire logic                              m_tready,
    input wire logic [wps_pkg::OUT_DATA_W-1:0]    m_tdata
);
    import wps_pkg::*;

    // a stalled result holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // one tick in work at a time
    a_one_tick: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("second request taken while a tick is in work");

    // waiting mode gives no drive command
    a_wait_no_drive: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tdata[30:29] == MODE_WAIT) |-> (m_tdata[28:0] == '0))
        else $error("drive fields set while waiting for start");

    // no command means zero speed and heading
    a_idle_fields: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tdata[0] |-> (m_tdata[28:1] == '0))
        else $error("speed or heading without a drive command");

    // result never appears in the cycle right after reset
    a_reset_quiet: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

endmodule

bind waypoint_approach_sequencer wps_checker u_wps_checker (.*);

`default_nettype wire
